[rtl/tksd_pkg.sv]
// Shared types and constants for the terminal key sequence decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tksd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KEY_W     = 4;
    localparam int unsigned CHAR_W    = 7;
    localparam int unsigned TICK_W    = 10;
    localparam int unsigned IN_DATA_W = 8;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(10);
    localparam logic [TICK_W-1:0] TICK_MAX      = '1;

    localparam logic [BYTE_W-1:0] B_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] B_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] B_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] B_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] B_ESC   = 8'd27;
    localparam logic [BYTE_W-1:0] B_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] B_TILDE = 8'd126;
    localparam logic [BYTE_W-1:0] B_DEL   = 8'd127;
    localparam logic [BYTE_W-1:0] B_LBRK  = 8'h5B;
    localparam logic [BYTE_W-1:0] B_O     = 8'h4F;
    localparam logic [BYTE_W-1:0] B_A     = 8'h41;
    localparam logic [BYTE_W-1:0] B_B     = 8'h42;
    localparam logic [BYTE_W-1:0] B_C     = 8'h43;
    localparam logic [BYTE_W-1:0] B_D     = 8'h44;
    localparam logic [BYTE_W-1:0] B_H     = 8'h48;
    localparam logic [BYTE_W-1:0] B_F     = 8'h46;
    localparam logic [BYTE_W-1:0] B_5     = 8'h35;
    localparam logic [BYTE_W-1:0] B_6     = 8'h36;
    localparam logic [BYTE_W-1:0] B_3     = 8'h33;

    typedef enum logic [KEY_W-1:0] {
        K_NORMAL    = 4'd0,
        K_ENTER     = 4'd1,
        K_SPACE     = 4'd2,
        K_TAB       = 4'd3,
        K_BACKSPACE = 4'd4,
        K_ESCAPE    = 4'd5,
        K_UP        = 4'd6,
        K_DOWN      = 4'd7,
        K_RIGHT     = 4'd8,
        K_LEFT      = 4'd9,
        K_HOME      = 4'd10,
        K_END       = 4'd11,
        K_PGUP      = 4'd12,
        K_PGDN      = 4'd13,
        K_DELETE    = 4'd14,
        K_UNKNOWN   = 4'd15
    } t_key;

    typedef struct packed {
        t_key              key;
        logic [CHAR_W-1:0] ch;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_result_word;

endpackage

[rtl/tksd_fsm.sv]
// Sequence state machine: decodes one input word per accepted cycle into at most one key word.
// Depends on tksd_pkg.
`timescale 1ns / 1ps

module tksd_fsm (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_kind,
    input  logic [tksd_pkg::BYTE_W-1:0]   i_byte,
    input  logic [tksd_pkg::TICK_W-1:0]   i_timeout,
    output tksd_pkg::t_result_word        o_word
);
    import tksd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ESC   = 2'd1,
        PH_CSI   = 2'd2,
        PH_TRAIL = 2'd3
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [TICK_W-1:0] r_tick_count, n_tick_count;
    t_key              r_pending, n_pending;
    logic [TICK_W-1:0] tick_inc;
    t_result_word      word;

    function automatic t_result decode_single(input logic [BYTE_W-1:0] b);
        t_result r;
        r.ch = '0;
        if (b == B_LF || b == B_CR) begin
            r.key = K_ENTER;
        end else if (b == B_SPACE) begin
            r.key = K_SPACE;
        end else if (b == B_TAB) begin
            r.key = K_TAB;
        end else if (b == B_BS || b == B_DEL) begin
            r.key = K_BACKSPACE;
        end else if (b > B_SPACE && b <= B_TILDE) begin
            r.key = K_NORMAL;
            r.ch  = b[CHAR_W-1:0];
        end else begin
            r.key = K_UNKNOWN;
        end
        return r;
    endfunction

    assign tick_inc = (r_tick_count == TICK_MAX) ? r_tick_count : r_tick_count + TICK_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_pending    = r_pending;
        word.valid   = 1'b0;
        word.res.key = K_UNKNOWN;
        word.res.ch  = '0;
        if (i_kind) begin
            if (r_phase == PH_ESC) begin
                if (tick_inc >= i_timeout) begin
                    n_phase      = PH_IDLE;
                    n_tick_count = '0;
                    word.valid   = 1'b1;
                    word.res.key = K_ESCAPE;
                end else begin
                    n_tick_count = tick_inc;
                end
            end
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_byte == B_ESC) begin
                        n_phase      = PH_ESC;
                        n_tick_count = '0;
                    end else begin
                        word.valid = 1'b1;
                        word.res   = decode_single(i_byte);
                    end
                end
                PH_ESC: begin
                    n_tick_count = '0;
                    if (i_byte == B_ESC) begin
                        n_phase      = PH_IDLE;
                        word.valid   = 1'b1;
                        word.res.key = K_ESCAPE;
                    end else if (i_byte == B_LBRK || i_byte == B_O) begin
                        n_phase = PH_CSI;
                    end else begin
                        n_phase    = PH_IDLE;
                        word.valid = 1'b1;
                    end
                end
                PH_CSI: begin
                    n_phase    = PH_IDLE;
                    word.valid = 1'b1;
                    case (i_byte)
                        B_A: word.res.key = K_UP;
                        B_B: word.res.key = K_DOWN;
                        B_C: word.res.key = K_RIGHT;
                        B_D: word.res.key = K_LEFT;
                        B_H: word.res.key = K_HOME;
                        B_F: word.res.key = K_END;
                        B_5: begin
                            n_pending  = K_PGUP;
                            n_phase    = PH_TRAIL;
                            word.valid = 1'b0;
                        end
                        B_6: begin
                            n_pending  = K_PGDN;
                            n_phase    = PH_TRAIL;
                            word.valid = 1'b0;
                        end
                        B_3: begin
                            n_pending  = K_DELETE;
                            n_phase    = PH_TRAIL;
                            word.valid = 1'b0;
                        end
                        default: word.res.key = K_UNKNOWN;
                    endcase
                end
                default: begin
                    n_phase      = PH_IDLE;
                    word.valid   = 1'b1;
                    word.res.key = r_pending;
                end
            endcase
        end
    end

    assign o_word.valid = word.valid & i_accept;
    assign o_word.res   = word.res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_pending    <= K_NORMAL;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_pending    <= n_pending;
        end
    end

endmodule

[rtl/tksd_out_buf.sv]
// Output register with a skid stage so the decoder accepts while a key word waits.
// Depends on tksd_pkg.
`timescale 1ns / 1ps

module tksd_out_buf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tksd_pkg::t_result_word i_word,
    input  logic                   i_ready,
    output logic                   o_full,
    output logic                   o_valid,
    output tksd_pkg::t_result      o_res
);
    import tksd_pkg::*;

    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;
    logic    pop;

    assign pop     = r_out_valid & i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_word.valid) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_word.valid) begin
            if (!r_out_valid || pop) begin
                r_out <= i_word.res;
            end else begin
                r_skid <= i_word.res;
            end
        end
    end

endmodule

[rtl/terminal_key_sequence_decoder.sv]
// Terminal key sequence decoder, top level.
// Depends on tksd_pkg, tksd_fsm and tksd_out_buf.
//
// Takes one word per cycle while input ready is high: a received byte (tuser 0)
// or a one millisecond tick (tuser 1), and emits at most one key word per
// input word. Decoding is combinational from the sequence state and the input
// word, so the key word lands in the output register at the accepting edge,
// or in the skid register when the output register still holds an unsent
// word. A two-deep output stage (register plus skid) keeps input ready high
// while a single key word waits; ready drops only when both hold words.
// The escape timeout register is written through the cfg channel, always
// ready, and should only be written while the decoder is idle.
`timescale 1ns / 1ps

module terminal_key_sequence_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tksd_pkg::TICK_W-1:0]      i_cfg_data,     // escape_timeout_ticks
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tksd_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] byte_value
    input  logic [0:0]                       s_axis_tuser,   // [0] kind
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [tksd_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // [3:0] key_code, [10:4] char_value
);
    import tksd_pkg::*;

    logic [TICK_W-1:0] r_timeout;
    logic              accept;
    logic              full;
    t_result_word      word;
    t_result           res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = ~full;
    assign accept        = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    tksd_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_kind    (s_axis_tuser[0]),
        .i_byte    (s_axis_tdata),
        .i_timeout (r_timeout),
        .o_word    (word)
    );

    tksd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (word),
        .i_ready (m_axis_tready),
        .o_full  (full),
        .o_valid (m_axis_tvalid),
        .o_res   (res)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - KEY_W - CHAR_W){1'b0}}, res.ch, res.key};

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("skid stage holds a word while the output register is empty");

    a_char_only_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[KEY_W-1:0] != K_NORMAL)
            |-> m_axis_tdata[KEY_W+CHAR_W-1:KEY_W] == '0)
        else $error("non-normal key carries a character");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> !word.valid)
        else $error("key word produced while the output stage is full");

endmodule
